[design/ptq_pkg.sv]
// ptq_pkg: word types, command type and function/status codes for the
// per-topic drop-oldest queues; no dependencies
`default_nettype none

package ptq_pkg;

	localparam int FUNC_W   = 2;
	localparam int TOPIC_W  = 5;
	localparam int HANDLE_W = 16;
	localparam int LIMIT_W  = 4;
	localparam int STATUS_W = 2;
	localparam int FILL_W   = 4;

	localparam logic [FUNC_W-1:0] FN_PUSH = 2'd0;
	localparam logic [FUNC_W-1:0] FN_POP  = 2'd1;
	localparam logic [FUNC_W-1:0] FN_SET  = 2'd2;
	localparam logic [FUNC_W-1:0] FN_NOP  = 2'd3;

	localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STS_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0]   func;
		logic [TOPIC_W-1:0]  topic;
		logic [HANDLE_W-1:0] handle_in;
		logic [LIMIT_W-1:0]  new_limit;
	} req_word_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [HANDLE_W-1:0] handle_out;
		logic                dropped_valid;
		logic [HANDLE_W-1:0] dropped_handle;
		logic [FILL_W-1:0]   fill;
	} rsp_word_t;

	// classified command passed from front to back
	typedef struct packed {
		logic                bad;
		logic [FUNC_W-1:0]   func;
		logic [TOPIC_W-1:0]  tidx;
		logic [LIMIT_W-1:0]  limit;
		logic [HANDLE_W-1:0] handle;
	} cmd_t;

endpackage

`default_nettype wire

[design/per_topic_drop_oldest_queues.sv]
// per_topic_drop_oldest_queues: top level, front classifier, command queue
// and back executor; uses ptq_pkg, ptq_front, ptq_cmd_queue, ptq_back
//
// Usage: request words (req) arrive on req_valid/req_stall and are accepted at
// an edge with req_valid high and req_stall low. Each request gives exactly one
// response word (rsp) on rsp_valid/rsp_stall, in request order.
// Push appends a handle to the topic's queue, dropping and reporting the oldest
// one if the queue is at or over its limit; pop returns the oldest handle; set changes
// the topic's limit (clamped to 1..DEPTH). Bad topics give a range status.
// The back end sequencer takes a new command only after the response for the
// last one is loaded: an execute step (pointer update plus one handle memory
// read), then a response step (response load).
// A two-entry command queue lets the front keep accepting while the back waits.
// Reset: all queues empty, all limits 1; the handle memory is not cleared and
// needs no clearing pass. When the receiver stalls, the response register holds
// its word, the back end stops after the current command, and once the queue
// fills req_stall goes high.
`default_nettype none

module per_topic_drop_oldest_queues
	import ptq_pkg::*;
#(
	parameter int TOPICS      = 16,
	parameter int DEPTH       = 8,
	parameter int HANDLE_BITS = 16
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire req_word_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output rsp_word_t      rsp
);

	logic q_push;
	logic q_full;
	cmd_t q_wdata;
	logic q_pop;
	cmd_t q_rdata;
	logic q_not_empty;

	ptq_front #(
		.TOPICS      (TOPICS),
		.DEPTH       (DEPTH),
		.HANDLE_BITS (HANDLE_BITS)
	) u_front (
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.q_push    (q_push),
		.q_data    (q_wdata),
		.q_full    (q_full)
	);

	ptq_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wdata     (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.rdata     (q_rdata),
		.not_empty (q_not_empty)
	);

	ptq_back #(
		.TOPICS      (TOPICS),
		.DEPTH       (DEPTH),
		.HANDLE_BITS (HANDLE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_not_empty),
		.cmd       (q_rdata),
		.cmd_take  (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

[design/ptq_front.sv]
// ptq_front: accepts request words, range-checks the topic, clamps the limit
// and masks the handle; uses ptq_pkg
`default_nettype none

module ptq_front
	import ptq_pkg::*;
#(
	parameter int TOPICS      = 16,
	parameter int DEPTH       = 8,
	parameter int HANDLE_BITS = 16
) (
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire req_word_t req,
	output logic           q_push,
	output cmd_t           q_data,
	input  wire logic      q_full
);

	localparam int SW = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
	localparam logic [HANDLE_W-1:0] HMASK = HANDLE_W'((33'(1) << SW) - 33'(1));

	logic [LIMIT_W-1:0] lim_clamped;

	assign req_stall = q_full;
	assign q_push    = req_valid && !q_full;

	always_comb begin
		if (req.new_limit == '0) begin
			lim_clamped = LIMIT_W'(1);
		end else if (32'(req.new_limit) > DEPTH) begin
			lim_clamped = LIMIT_W'(DEPTH);
		end else begin
			lim_clamped = req.new_limit;
		end
	end

	always_comb begin
		q_data.bad    = (req.topic == '0) || (32'(req.topic) > TOPICS);
		q_data.func   = req.func;
		q_data.tidx   = req.topic - TOPIC_W'(1);
		q_data.limit  = lim_clamped;
		q_data.handle = req.handle_in & HMASK;
	end

endmodule

`default_nettype wire

[design/ptq_cmd_queue.sv]
// ptq_cmd_queue: two-entry command queue between front and back
// uses ptq_pkg
`default_nettype none

module ptq_cmd_queue
	import ptq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t wdata,
	output logic      full,
	input  wire logic pop,
	output cmd_t      rdata,
	output logic      not_empty
);

	logic [1:0] cnt_q;
	logic       wp_q;
	logic       rp_q;
	cmd_t       slot_q [2];

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign rdata     = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

[design/ptq_back.sv]
// ptq_back: per-topic pointer update, handle memory and response register
// uses ptq_pkg
`default_nettype none

module ptq_back
	import ptq_pkg::*;
#(
	parameter int TOPICS      = 16,
	parameter int DEPTH       = 8,
	parameter int HANDLE_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	input  wire cmd_t cmd,
	output logic      cmd_take,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_word_t rsp
);

	localparam int SW   = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
	localparam int TIW  = (TOPICS > 1) ? $clog2(TOPICS) : 1;
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int HW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SUMW = $clog2(2 * DEPTH);
	localparam int MAW  = (TOPICS * DEPTH > 1) ? $clog2(TOPICS * DEPTH) : 1;

	localparam logic S_EXEC = 1'b0;
	localparam logic S_RESP = 1'b1;

	logic                state_q;
	logic [HW-1:0]       head_q [TOPICS];
	logic [CW-1:0]       cnt_q  [TOPICS];
	logic [LIMIT_W-1:0]  lim_q  [TOPICS];
	logic [SW-1:0]       handle_store_q [TOPICS*DEPTH];

	logic [SW-1:0]       rd_s1;
	logic [STATUS_W-1:0] sts_s1;
	logic                drop_s1;
	logic                pop_s1;
	logic [FILL_W-1:0]   fill_s1;

	rsp_word_t           rsp_q;
	logic                rsp_valid_q;

	logic [TIW-1:0]      t;
	logic [HW-1:0]       h;
	logic [CW-1:0]       c;
	logic [LIMIT_W-1:0]  l;
	logic [HW-1:0]       hinc;
	logic [SUMW-1:0]     sum;
	logic [HW-1:0]       tail;
	logic                full_drop;
	logic [HW-1:0]       h_nx;
	logic [CW-1:0]       c_nx;
	logic [LIMIT_W-1:0]  l_nx;
	logic [STATUS_W-1:0] sts;
	logic                do_drop;
	logic                do_pop;
	logic                mem_we;
	logic                mem_re;
	logic [MAW-1:0]      base;
	logic [MAW-1:0]      ra;
	logic [MAW-1:0]      wa;

	assign cmd_take  = cmd_valid && (state_q == S_EXEC) && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		t         = cmd.tidx[TIW-1:0];
		h         = head_q[t];
		c         = cnt_q[t];
		l         = lim_q[t];
		hinc      = (32'(h) + 1 == DEPTH) ? '0 : HW'(32'(h) + 1);
		sum       = SUMW'(h) + SUMW'(c);
		tail      = (32'(sum) >= DEPTH) ? HW'(32'(sum) - DEPTH) : HW'(sum);
		full_drop = (32'(c) >= 32'(l)) && (c != '0);
		h_nx      = h;
		c_nx      = c;
		l_nx      = l;
		sts       = STS_OK;
		do_drop   = 1'b0;
		do_pop    = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		if (cmd.bad) begin
			sts = STS_RANGE;
		end else begin
			unique case (cmd.func)
				FN_PUSH: begin
					mem_we = 1'b1;
					if (full_drop) begin
						do_drop = 1'b1;
						mem_re  = 1'b1;
						h_nx    = hinc;
					end else begin
						c_nx = c + CW'(1);
					end
				end
				FN_POP: begin
					if (c == '0) begin
						sts = STS_EMPTY;
					end else begin
						do_pop = 1'b1;
						mem_re = 1'b1;
						h_nx   = hinc;
						c_nx   = c - CW'(1);
					end
				end
				FN_SET: begin
					l_nx = cmd.limit;
				end
				FN_NOP: begin
				end
				default: begin
				end
			endcase
		end
		base = MAW'(t) * MAW'(DEPTH);
		ra   = base + MAW'(h);
		wa   = base + MAW'(tail);
	end

	// read-first: a drop on a full queue reads the old head before overwrite
	always_ff @(posedge clk) begin
		if (cmd_take && mem_re) begin
			rd_s1 <= handle_store_q[ra];
		end
		if (cmd_take && mem_we) begin
			handle_store_q[wa] <= cmd.handle[SW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			sts_s1  <= sts;
			drop_s1 <= do_drop;
			pop_s1  <= do_pop;
			fill_s1 <= cmd.bad ? '0 : FILL_W'(c_nx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TOPICS; i++) begin
				head_q[i] <= '0;
				cnt_q[i]  <= '0;
				lim_q[i]  <= LIMIT_W'(1);
			end
		end else if (cmd_take && !cmd.bad) begin
			head_q[t] <= h_nx;
			cnt_q[t]  <= c_nx;
			lim_q[t]  <= l_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESP) begin
			rsp_q.status         <= sts_s1;
			rsp_q.handle_out     <= pop_s1 ? HANDLE_W'(rd_s1) : '0;
			rsp_q.dropped_valid  <= drop_s1;
			rsp_q.dropped_handle <= drop_s1 ? HANDLE_W'(rd_s1) : '0;
			rsp_q.fill           <= fill_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_EXEC;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_EXEC: begin
					if (cmd_take) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					rsp_valid_q <= 1'b1;
					state_q     <= S_EXEC;
				end
				default: begin
					state_q <= S_EXEC;
				end
			endcase
		end
	end

	a_rsp_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == S_RESP)
		else $error("response word loaded outside response step");

	a_resp_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RESP |=> state_q == S_EXEC && rsp_valid_q)
		else $error("response step did not complete");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take && !cmd.bad |-> 32'(c) <= DEPTH)
		else $error("queue count beyond depth");

	a_drop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.dropped_valid |-> rsp_q.status == STS_OK && rsp_q.handle_out == '0)
		else $error("drop reported with bad status or pop data");

endmodule

`default_nettype wire

[verif/per_topic_drop_oldest_queues_tb.sv]
// per_topic_drop_oldest_queues_tb: self-checking bench for the per-topic drop-oldest queues,
// with a request driver, a response monitor and a scoreboard that models every topic queue
// depends on ptq_pkg and per_topic_drop_oldest_queues
`timescale 1ns / 100ps

module per_topic_drop_oldest_queues_tb;
	import ptq_pkg::*;

	localparam int TOPICS      = 16;
	localparam int DEPTH       = 8;
	localparam int HANDLE_BITS = 16;
	localparam int RANDOM_CMDS = 1700;

	typedef struct packed {
		req_word_t word;
		logic      drain_first;
	} cmd_item_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_word_t req       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_word_t rsp;

	cmd_item_t cmd_backlog[$];
	rsp_word_t predicted_rsp[$];
	cmd_item_t next_cmd;

	// scoreboard copy of every topic queue
	logic [HANDLE_BITS-1:0] handle_mem[1:TOPICS][0:DEPTH-1];
	logic [2:0]             head_ptr[1:TOPICS];
	logic [3:0]             entry_cnt[1:TOPICS];
	logic [3:0]             depth_lim[1:TOPICS];

	int  err_count = 0;
	int  rsp_seen  = 0;
	bit  req_taken = 1'b0;
	int  burst_left = 1;
	int  gap_left   = 0;
	int  stall_pct  = 0;
	int  mode_left  = 0;
	int  hold_left  = 0;
	int  next_hold_at = 300;

	per_topic_drop_oldest_queues #(
		.TOPICS(TOPICS),
		.DEPTH(DEPTH),
		.HANDLE_BITS(HANDLE_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic rsp_word_t apply_topic_cmd(req_word_t w);
		rsp_word_t r;
		logic [4:0] t;
		logic [3:0] lim;
		r = '0;
		if (w.topic < 1 || w.topic > TOPICS) begin
			r.status = STS_RANGE;
			return r;
		end
		t = w.topic;
		case (w.func)
			FN_PUSH: begin
				if (entry_cnt[t] >= depth_lim[t] && entry_cnt[t] > 0) begin
					r.dropped_valid  = 1'b1;
					r.dropped_handle = handle_mem[t][head_ptr[t]];
					head_ptr[t]      = head_ptr[t] + 3'd1;
					entry_cnt[t]     = entry_cnt[t] - 4'd1;
				end
				if (entry_cnt[t] < DEPTH) begin
					handle_mem[t][3'(head_ptr[t] + entry_cnt[t])] = w.handle_in;
					entry_cnt[t] = entry_cnt[t] + 4'd1;
				end
			end
			FN_POP: begin
				if (entry_cnt[t] == 0) begin
					r.status = STS_EMPTY;
				end else begin
					r.handle_out = handle_mem[t][head_ptr[t]];
					head_ptr[t]  = head_ptr[t] + 3'd1;
					entry_cnt[t] = entry_cnt[t] - 4'd1;
				end
			end
			FN_SET: begin
				lim = w.new_limit;
				if (lim < 1)
					lim = 4'd1;
				if (lim > DEPTH)
					lim = 4'(DEPTH);
				depth_lim[t] = lim;
			end
			default: ;
		endcase
		r.fill = entry_cnt[t];
		return r;
	endfunction

	function automatic cmd_item_t cmd_item(logic [FUNC_W-1:0] f, logic [TOPIC_W-1:0] t,
			logic [HANDLE_W-1:0] h, logic [LIMIT_W-1:0] l, logic drain);
		cmd_item_t c;
		c.word.func      = f;
		c.word.topic     = t;
		c.word.handle_in = h;
		c.word.new_limit = l;
		c.drain_first    = drain;
		return c;
	endfunction

	function automatic cmd_item_t random_cmd(int push_pct, bit drain);
		int roll;
		logic [FUNC_W-1:0]  f;
		logic [TOPIC_W-1:0] t;
		roll = $urandom_range(0, 99);
		if (roll < push_pct)
			f = FN_PUSH;
		else if (roll < 88)
			f = FN_POP;
		else if (roll < 96)
			f = FN_SET;
		else
			f = FN_NOP;
		roll = $urandom_range(0, 99);
		if (roll < 8)
			t = ($urandom_range(0, 1) == 0) ? 5'd0 : 5'($urandom_range(TOPICS + 1, 31));
		else if (roll < 65)
			t = 5'($urandom_range(1, 4));
		else
			t = 5'($urandom_range(1, TOPICS));
		return cmd_item(f, t, 16'($urandom), 4'($urandom_range(0, 15)), drain);
	endfunction

	// request driver
	always @(negedge clk) begin
		if (arst_n && (!req_valid || req_taken)) begin
			if (gap_left != 0) begin
				req_valid <= 1'b0;
				gap_left = gap_left - 1;
			end else if (cmd_backlog.size() != 0 &&
					!(cmd_backlog[0].drain_first && predicted_rsp.size() != 0)) begin
				next_cmd = cmd_backlog.pop_front();
				req       <= next_cmd.word;
				req_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 40);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left = burst_left - 1;
				end
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// response stall pattern, with a long hold now and then
	always @(negedge clk) begin
		if (hold_left != 0) begin
			rsp_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else if (rsp_seen >= next_hold_at) begin
			rsp_stall <= 1'b1;
			hold_left = 80;
			next_hold_at = next_hold_at + 700;
		end else begin
			if (mode_left == 0) begin
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 25;
					2: stall_pct = 60;
					default: stall_pct = 90;
				endcase
				mode_left = $urandom_range(20, 80);
			end
			mode_left = mode_left - 1;
			rsp_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	task automatic check_field(string fname, logic [15:0] exp_val, logic [15:0] act_val);
		if (act_val !== exp_val) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, fname, exp_val, act_val);
			err_count++;
		end
	endtask

	// request capture and response monitor
	always @(posedge clk) begin
		rsp_word_t exp_rsp;
		req_taken = arst_n && req_valid && !req_stall;
		if (req_taken)
			predicted_rsp.push_back(apply_topic_cmd(req));
		if (arst_n && rsp_valid && !rsp_stall) begin
			rsp_seen++;
			if (predicted_rsp.size() == 0) begin
				$display("%0t: unexpected response word, expected none actual %h", $time, rsp);
				err_count++;
			end else begin
				exp_rsp = predicted_rsp.pop_front();
				check_field("status", 16'(exp_rsp.status), 16'(rsp.status));
				check_field("handle_out", exp_rsp.handle_out, rsp.handle_out);
				check_field("dropped_valid", 16'(exp_rsp.dropped_valid), 16'(rsp.dropped_valid));
				check_field("dropped_handle", exp_rsp.dropped_handle, rsp.dropped_handle);
				check_field("fill", 16'(exp_rsp.fill), 16'(rsp.fill));
			end
		end
	end

	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int push_pct;
		for (int t = 1; t <= TOPICS; t++) begin
			head_ptr[t]  = '0;
			entry_cnt[t] = '0;
			depth_lim[t] = 4'd1;
		end

		// bad topics, including the no-op function code
		cmd_backlog.push_back(cmd_item(FN_PUSH, 5'd0, 16'h1234, 4'd0, 1'b0));
		cmd_backlog.push_back(cmd_item(FN_POP, 5'd17, 16'h0000, 4'd0, 1'b0));
		cmd_backlog.push_back(cmd_item(FN_SET, 5'd31, 16'hffff, 4'd15, 1'b0));
		cmd_backlog.push_back(cmd_item(FN_NOP, 5'd0, 16'h0000, 4'd0, 1'b0));
		// empty pop, then drop with the reset limit
		cmd_backlog.push_back(cmd_item(FN_POP, 5'd1, 16'h0000, 4'd0, 1'b0));
		cmd_backlog.push_back(cmd_item(FN_PUSH, 5'd1, 16'hffff, 4'd0, 1'b0));
		cmd_backlog.push_back(cmd_item(FN_PUSH, 5'd1, 16'h0000, 4'd0, 1'b0));
		// limit clamps at both ends
		cmd_backlog.push_back(cmd_item(FN_SET, 5'd1, 16'h0000, 4'd0, 1'b0));
		cmd_backlog.push_back(cmd_item(FN_SET, 5'd16, 16'h0000, 4'd15, 1'b0));
		cmd_backlog.push_back(cmd_item(FN_SET, 5'd16, 16'h0000, 4'd8, 1'b0));
		for (int i = 0; i < 9; i++)
			cmd_backlog.push_back(cmd_item(FN_PUSH, 5'd16, 16'(16'ha5a0 + i), 4'd0, 1'b0));
		// limit lowered below fill
		cmd_backlog.push_back(cmd_item(FN_SET, 5'd16, 16'h0000, 4'd2, 1'b0));
		cmd_backlog.push_back(cmd_item(FN_PUSH, 5'd16, 16'h5a5a, 4'd0, 1'b0));
		cmd_backlog.push_back(cmd_item(FN_POP, 5'd16, 16'h0000, 4'd0, 1'b0));
		cmd_backlog.push_back(cmd_item(FN_NOP, 5'd16, 16'hffff, 4'd15, 1'b0));
		cmd_backlog.push_back(cmd_item(FN_POP, 5'd1, 16'h0000, 4'd0, 1'b0));

		push_pct = 50;
		for (int i = 0; i < RANDOM_CMDS; i++) begin
			if (i % 100 == 0) begin
				case ($urandom_range(0, 2))
					0: push_pct = 30;
					1: push_pct = 50;
					default: push_pct = 70;
				endcase
			end
			cmd_backlog.push_back(random_cmd(push_pct, (i % 400) == 0));
		end

		repeat (5) @(posedge clk);
		#5 arst_n = 1'b1;

		while (cmd_backlog.size() != 0 || req_valid || predicted_rsp.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (err_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

[sim.f]
design/ptq_pkg.sv
design/ptq_front.sv
design/ptq_cmd_queue.sv
design/ptq_back.sv
design/per_topic_drop_oldest_queues.sv
verif/per_topic_drop_oldest_queues_tb.sv
